// File: hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Types and codes shared by the deque controller, datapath and top level.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_DEPTH = 16;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_READ       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value;
		logic [7:0]         position;
	} dq_req_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic               is_empty;
		logic [4:0]         entry_count;
	} dq_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} dq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;
	} dq_flags_t;

endpackage

// File: hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, front pointer, entry count and result register of the deque.
// ----------------------------------------------------------------------------
module dq_datapath
	import dq_pkg::*;
#(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dq_cmd_t   cmd,
	output dq_flags_t flags,
	input  dq_req_t   req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output dq_rsp_t   rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

	logic [31:0]      mem [DEPTH];
	dq_req_t          req_q;
	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;
	logic             rd_ok_q;
	logic [31:0]      rd_data_q;
	logic             rsp_valid_q;
	dq_rsp_t          rsp_q;

	logic             full;
	logic             empty;
	logic             pos_out;
	logic [CNT_W-1:0] offset;
	logic [CNT_W:0]   ring_sum;
	logic [CNT_W:0]   ring_wrap;
	logic [PTR_W-1:0] ring_idx;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] front_inc;
	logic [PTR_W-1:0] addr;
	logic             wr_en;
	logic             rd_en;
	logic [1:0]       status_d;
	logic [PTR_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W+8:0] pos_x;
	logic [CNT_W+8:0] cnt_x;
	logic [CNT_W+4:0] cnt_out_x;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pos_x = (CNT_W + 9)'(req_q.position);
	assign cnt_x = (CNT_W + 9)'(count_q);
	assign pos_out = (pos_x >= cnt_x);

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - PTR_W'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + PTR_W'(1);

	// one shared ring adder; offset is always below DEPTH when used
	always_comb begin
		case (req_q.mode)
			MODE_POP_BACK: offset = count_q - CNT_W'(1);
			MODE_READ:     offset = CNT_W'(req_q.position);
			default:       offset = count_q;
		endcase
	end

	assign ring_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(offset);
	assign ring_wrap = (ring_sum >= DEPTH_X) ? ring_sum - DEPTH_X : ring_sum;
	assign ring_idx  = ring_wrap[PTR_W-1:0];

	always_comb begin
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		status_d = ST_OK;
		addr     = ring_idx;
		front_d  = front_q;
		count_d  = count_q;
		case (req_q.mode)
			MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					addr    = front_dec;
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					addr    = front_q;
					front_d = front_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_READ: begin
				if (pos_out) begin
					status_d = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[addr] <= req_q.value;
		end
		if (cmd.exec) begin
			rd_data_q <= mem[addr];
			rd_ok_q   <= rd_en;
			status_q  <= status_d;
		end
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	assign cnt_out_x = (CNT_W + 5)'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.data        <= rd_ok_q ? rd_data_q : '0;
			rsp_q.status      <= status_q;
			rsp_q.is_empty    <= empty;
			rsp_q.entry_count <= cnt_out_x[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign flags.out_busy = rsp_valid_q && rsp_stall;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

endmodule

// File: hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequences one request: capture, execute against the store, load result.
// ----------------------------------------------------------------------------
module dq_ctrl
	import dq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dq_flags_t flags,
	output dq_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign accept = req_valid && !stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
						stall_q <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					// wait here while the previous result is still held
					if (!flags.out_busy) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign req_stall    = stall_q;
	assign cmd.capture  = accept;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.load_out = (state_q == S_RESP) && !flags.out_busy;

endmodule

// File: hw/rtl/bounded_deque_with_index_read_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_unit
// Bounded double-ended queue of signed 32-bit values in a ring store, with
// push/pop at both ends and read by position from the front.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------
//   req     | in        | req_valid/req_stall | dq_req_t
//   rsp     | out       | rsp_valid/rsp_stall | dq_rsp_t
//
// Each request goes through capture, one store access (single port,
// registered read), result load. A new request is taken once the previous
// result is in the output register, which may still wait on rsp_stall; a
// held result delays only the load step of the next request.
// Reset clears front pointer and count; store contents are not reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_unit
	import dq_pkg::*;
#(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  dq_req_t req,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dq_rsp_t rsp
);

	dq_cmd_t   cmd;
	dq_flags_t flags;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	dq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.flags     (flags),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque unit, attached by bind.
// ----------------------------------------------------------------------------
module dq_checker
	import dq_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    req_valid,
	input logic    req_stall,
	input dq_req_t req,
	input logic    rsp_valid,
	input logic    rsp_stall,
	input dq_rsp_t rsp
);

	// a held result stays put until transferred
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one request in flight: stall rises right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// refused or out of range requests return zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.data == '0)
		else $error("nonzero data on error status");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.is_empty && rsp.entry_count == '0)
		else $error("empty status with entries held");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> !rsp.is_empty)
		else $error("full status on empty queue");

endmodule

bind bounded_deque_with_index_read_unit dq_checker u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: sim/tb_bounded_deque_with_index_read_unit.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_index_read_unit
// Self-checking bench for the bounded deque. A directed sequence covers empty
// pops, full pushes, out-of-range reads, unused modes and value extremes.
// Random traffic follows, in bursts that lean toward growth, shrinkage or a mix.
// Each request transfer updates a local deque model, and each response
// transfer is compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_index_read_unit;
	import dq_pkg::*;

	typedef struct {
		dq_req_t req;
		bit      hold;   // wait for all responses before sending this one
	} pending_req_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    req_valid;
	logic    req_stall;
	dq_req_t req;
	logic    rsp_valid;
	logic    rsp_stall;
	dq_rsp_t rsp;

	pending_req_t req_queue[$];
	dq_rsp_t      rsp_expected[$];
	bit           req_taken;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           error_count;

	// deque model state
	logic signed [31:0] ring[DQ_DEPTH];
	int                 head;
	int                 fill;

	bounded_deque_with_index_read_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dq_rsp_t deque_step(input dq_req_t r);
		dq_rsp_t o;
		o = '0;
		o.status = ST_OK;
		case (r.mode)
			MODE_PUSH_FRONT: begin
				if (fill >= DQ_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
					ring[head] = r.value;
					fill++;
				end
			end
			MODE_PUSH_BACK: begin
				if (fill >= DQ_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					ring[(head + fill) % DQ_DEPTH] = r.value;
					fill++;
				end
			end
			MODE_POP_FRONT: begin
				if (fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data = ring[head];
					head = (head + 1) % DQ_DEPTH;
					fill--;
				end
			end
			MODE_POP_BACK: begin
				if (fill == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.data = ring[(head + fill - 1) % DQ_DEPTH];
					fill--;
				end
			end
			MODE_READ: begin
				if (int'(r.position) >= fill) begin
					o.status = ST_RANGE;
				end else begin
					o.data = ring[(head + int'(r.position)) % DQ_DEPTH];
				end
			end
			default: begin
			end
		endcase
		o.is_empty    = (fill == 0);
		o.entry_count = 5'(fill);
		return o;
	endfunction

	task automatic add_req(input logic [2:0] m, input logic signed [31:0] v,
			input logic [7:0] p, input bit hold);
		pending_req_t item;
		item.req.mode     = m;
		item.req.value    = v;
		item.req.position = p;
		item.hold         = hold;
		req_queue.insert(req_queue.size(), item);
	endtask

	// Bursts lean toward growth, shrinkage or a mix so both full and empty
	// are hit repeatedly.
	task automatic add_random_reqs(input int n);
		int                 made;
		int                 burst;
		int                 lean;
		int                 pick;
		int                 push_pct;
		logic [2:0]         m;
		logic signed [31:0] v;
		logic [7:0]         p;
		made  = 0;
		burst = 0;
		lean  = 2;
		while (made < n) begin
			if (burst == 0) begin
				lean  = $urandom_range(2);
				burst = $urandom_range(16, 40);
			end
			burst--;
			push_pct = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
			pick = $urandom_range(99);
			if (pick < 4) begin
				m = MODE_READ + 3'($urandom_range(1, 3));
			end else if (pick < 22) begin
				m = MODE_READ;
			end else if ($urandom_range(99) < push_pct) begin
				m = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
			end else begin
				m = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
			end
			case ($urandom_range(19))
				0:       v = 32'sh8000_0000;
				1:       v = 32'sh7fff_ffff;
				2:       v = 32'sh0;
				3:       v = -32'sd1;
				default: v = $urandom;
			endcase
			p = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(17));
			add_req(m, v, p, $urandom_range(199) == 0);
			if (m <= MODE_READ)
				made++;
		end
	endtask

	task automatic wait_drained();
		while (req_queue.size() != 0 || req_valid || rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	// request driver: new payload only after the previous transfer
	always @(negedge clk) begin : drive_req
		logic    next_valid;
		dq_req_t next_req;
		if (arst_n && !(req_valid && !req_taken)) begin
			next_valid = 1'b0;
			next_req   = req;
			if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& !(req_queue[0].hold && rsp_expected.size() != 0)) begin
				next_req   = req_queue[0].req;
				req_queue.delete(0);
				next_valid = 1'b1;
			end
			req_valid <= next_valid;
			req       <= next_req;
		end
		req_taken = 1'b0;
		if (arst_n)
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// transfer monitor: check responses, then predict for accepted requests
	always @(posedge clk) begin : watch
		dq_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected.size() == 0) begin
					$error("response transfer with no request outstanding");
					error_count++;
				end else begin
					want = rsp_expected[0];
					rsp_expected.delete(0);
					if (rsp.data !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, rsp.data);
						error_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						error_count++;
					end
					if (rsp.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty,
							rsp.is_empty);
						error_count++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							rsp.entry_count);
						error_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				rsp_expected.insert(rsp_expected.size(), deque_step(req));
				req_taken = 1'b1;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		req_taken     = 1'b0;
		error_count   = 0;
		head          = 0;
		fill          = 0;
		send_idle_pct = 10;
		recv_idle_pct = 77;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue corner cases and an unused mode
		add_req(MODE_POP_FRONT, 32'sd0, 8'd0, 1'b0);
		add_req(MODE_POP_BACK, 32'sd0, 8'd0, 1'b0);
		add_req(MODE_READ, 32'sd0, 8'd0, 1'b0);
		add_req(MODE_READ + 3'd3, 32'sh7fff_ffff, 8'hff, 1'b0);
		// fill from both ends with extreme values
		add_req(MODE_PUSH_FRONT, 32'sh8000_0000, 8'd0, 1'b0);
		add_req(MODE_PUSH_BACK, 32'sh7fff_ffff, 8'd0, 1'b0);
		add_req(MODE_PUSH_FRONT, -32'sd1, 8'd0, 1'b0);
		add_req(MODE_PUSH_BACK, 32'sd0, 8'd0, 1'b0);
		for (int i = 0; i < DQ_DEPTH - 4; i++)
			add_req(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom, 8'd0, 1'b0);
		// full queue
		add_req(MODE_PUSH_FRONT, 32'sd1, 8'd0, 1'b0);
		add_req(MODE_PUSH_BACK, 32'sd2, 8'd0, 1'b0);
		add_req(MODE_READ, 32'sd0, 8'(DQ_DEPTH - 1), 1'b0);
		add_req(MODE_READ, 32'sd0, 8'(DQ_DEPTH), 1'b0);
		add_req(MODE_READ, 32'sd0, 8'hff, 1'b0);
		add_req(MODE_READ + 3'd1, 32'sd0, 8'd0, 1'b0);
		add_req(MODE_POP_FRONT, 32'sd0, 8'd0, 1'b0);
		add_req(MODE_POP_BACK, 32'sd0, 8'd0, 1'b0);
		add_random_reqs(480);
		wait_drained();

		send_idle_pct = 77;
		recv_idle_pct = 10;
		add_random_reqs(510);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_reqs(510);
		wait_drained();

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/bounded_deque_with_index_read_unit.sv
hw/rtl/dq_checker.sv
sim/tb_bounded_deque_with_index_read_unit.sv
